// ===== rtl/chained_hash_node_pool_top_macros.svh =====
// Assertion helpers for the node pool.
`ifndef CHAINED_HASH_NODE_POOL_TOP_MACROS_SVH
`define CHAINED_HASH_NODE_POOL_TOP_MACROS_SVH

// Clocked implication, disabled in reset.
`define CHNP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/chnp_pkg.sv =====
package chnp_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned TAG_W    = 8;
    localparam int unsigned MAXM_W   = 4;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned LIMIT_W  = 11;
    localparam int unsigned RES_CAP  = 8;

    // Bucket table size; a power of two, so the bucket is the low hash bits.
    localparam int unsigned BUCKET_COUNT = 256;

    localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] ST_FOUND   = 3'd0;
    localparam logic [STAT_W-1:0] ST_CREATED = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISS    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

    // Controller to datapath.
    typedef struct packed {
        logic take;        // latch the command beat
        logic head_rd;     // issue bucket head read
        logic head_load;   // pointer from head read data
        logic node_rd;     // issue entry read at pointer
        logic node_adv;    // pointer from link read data
        logic alloc;       // write new entry, relink head, bump count
        logic clr_start;   // begin head sweep, zero count
        logic clr_step;    // sweep one head
        logic hit_push;    // count one reported match
        logic pend_load;   // hold the current match back
        logic res_load;    // load result register
        logic [STAT_W-1:0] res_status;
        logic res_use_ptr; // index from pointer, else from count/held match/zero
        logic res_use_cnt;
        logic res_use_pend;
        logic res_last;
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic ptr_live;
        logic key_eq;
        logic tag_eq;
        logic full;
        logic cap_zero;
        logic cap_reached;  // hits so far + 1 == cap
        logic hits_zero;
        logic clr_done;
        logic res_busy;
    } t_sts;

    function automatic logic [KEY_W-1:0] mix_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] v;
        v = k;
        v = v + ~(v << 15);
        v = v ^ (v >> 10);
        v = v + (v << 3);
        v = v ^ (v >> 6);
        v = v + ~(v << 11);
        v = v ^ (v >> 16);
        return v;
    endfunction

endpackage

// ===== rtl/chnp_if.sv =====
interface chnp_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [chnp_pkg::CMD_W-1:0]    command;
    logic [chnp_pkg::KEY_W-1:0]    key;
    logic [chnp_pkg::TAG_W-1:0]    tag;
    logic [chnp_pkg::MAXM_W-1:0]   max_matches;
    modport source (output valid, command, key, tag, max_matches, input ready);
    modport sink (input valid, command, key, tag, max_matches, output ready);
endinterface

// ===== rtl/chnp_res_if.sv =====
interface chnp_res_if;
    logic                          valid;
    logic                          ready;
    logic [chnp_pkg::IDX_W-1:0]    entry_index;
    logic [chnp_pkg::STAT_W-1:0]   status;
    logic                          last;
    modport source (output valid, entry_index, status, last, input ready);
    modport sink (input valid, entry_index, status, last, output ready);
endinterface

// ===== rtl/chnp_cfg_if.sv =====
interface chnp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [chnp_pkg::LIMIT_W-1:0]    data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/chained_hash_node_pool_top.sv =====
// Channel  | Dir | Beat carries                              | Accepted when
// cmd      | in  | command, key, tag, max_matches            | valid && ready
// res      | out | entry_index, status, last                 | valid && ready
// cfg      | in  | node_limit (11 bits)                      | valid && ready (always ready)
//
// Flow: accept, head read, head RAM latency and pointer load reach the first entry,
// then each entry walked needs a registered entry read and a compare; a get or find
// hit ends there, a walk that runs out closes and decides. Find-all holds each match
// back one step so the final beat carries last; a held match goes out from S_OUT.
// Clear sweeps the bucket valid bits one per cycle.
// Reset: synchronous, active low; empties the pool at once via the bucket valid bits.
// Stalls: the result register holds a beat while res.ready is low; the walk waits on it.
`include "chained_hash_node_pool_top_macros.svh"

module chained_hash_node_pool_top #(
    parameter int unsigned POOL_DEPTH   = 1024,
    parameter int unsigned MATCH_LIMIT  = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    chnp_cmd_if.sink   cmd,
    chnp_res_if.source res,
    chnp_cfg_if.sink   cfg
);
    chnp_pkg::t_ctl w_ctl;
    chnp_pkg::t_sts w_sts;

    // The user is to write configuration only while idle; the block leaves this to the user and always takes it.
    assign cfg.ready = 1'b1;

    chnp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd.valid), .o_cmd_ready(cmd.ready),
        .o_ctl(w_ctl), .i_sts(w_sts));

    chnp_datapath #(
        .POOL_DEPTH(POOL_DEPTH), .MATCH_LIMIT(MATCH_LIMIT)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctl(w_ctl), .o_sts(w_sts),
        .i_command(cmd.command), .i_key(cmd.key), .i_tag(cmd.tag),
        .i_max_matches(cmd.max_matches),
        .i_cfg_we(cfg.valid), .i_cfg_data(cfg.data),
        .i_res_take(res.ready),
        .o_res_valid(res.valid), .o_res_index(res.entry_index),
        .o_res_status(res.status), .o_res_last(res.last));

    `CHNP_ASSERT_IMPL(a_cmd_busy, i_clk, i_rst_n, res.valid && !res.ready, !w_ctl.res_load, "result overwritten under stall")
    `CHNP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, res.valid && !res.ready, res.valid, "result dropped under stall")
    `CHNP_ASSERT_IMPL(a_ready_quiet, i_clk, i_rst_n, cmd.ready, !w_ctl.alloc, "alloc while idle")
endmodule

// ===== rtl/chnp_ram.sv =====
module chnp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/chnp_datapath.sv =====
`include "chained_hash_node_pool_top_macros.svh"

module chnp_datapath #(
    parameter int unsigned POOL_DEPTH   = 1024,
    parameter int unsigned MATCH_LIMIT  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  chnp_pkg::t_ctl              i_ctl,
    output chnp_pkg::t_sts              o_sts,
    input  logic [chnp_pkg::CMD_W-1:0]  i_command,
    input  logic [chnp_pkg::KEY_W-1:0]  i_key,
    input  logic [chnp_pkg::TAG_W-1:0]  i_tag,
    input  logic [chnp_pkg::MAXM_W-1:0] i_max_matches,
    input  logic                        i_cfg_we,
    input  logic [chnp_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_res_take,
    output logic                        o_res_valid,
    output logic [chnp_pkg::IDX_W-1:0]  o_res_index,
    output logic [chnp_pkg::STAT_W-1:0] o_res_status,
    output logic                        o_res_last
);
    localparam int unsigned BUCKET_COUNT = chnp_pkg::BUCKET_COUNT;
    localparam int unsigned PW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(POOL_DEPTH + 1);   // count / link width
    localparam int unsigned BW  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int unsigned BCW = $clog2(BUCKET_COUNT + 1);
    localparam int unsigned CAPV = (MATCH_LIMIT < chnp_pkg::RES_CAP) ?
                                   MATCH_LIMIT : chnp_pkg::RES_CAP;
    localparam int unsigned HW  = $clog2(CAPV + 1);
    localparam logic [CW-1:0] NULL_LINK = CW'(POOL_DEPTH);

    logic [chnp_pkg::CMD_W-1:0]  r_cmd;
    logic [chnp_pkg::KEY_W-1:0]  r_key;
    logic [chnp_pkg::TAG_W-1:0]  r_tag;
    logic [chnp_pkg::MAXM_W-1:0] r_cap;
    logic [BW-1:0]               r_bucket;
    logic [CW-1:0]               r_ptr;
    logic [CW-1:0]               r_pend;
    logic [CW-1:0]               r_count;
    logic [chnp_pkg::LIMIT_W-1:0] r_limit;
    logic [HW-1:0]               r_hits;
    logic [BW-1:0]               r_clr_addr;
    logic                        r_clr_done;
    logic [BUCKET_COUNT-1:0]     r_head_vld;
    logic                        r_head_vld_q;
    logic                        r_res_valid;
    logic [chnp_pkg::IDX_W-1:0]  r_res_index;
    logic [chnp_pkg::STAT_W-1:0] r_res_status;
    logic                        r_res_last;

    logic [CW-1:0] w_head_rd, w_link_rd, w_head_eff, w_head_wdata;
    logic [chnp_pkg::KEY_W-1:0] w_key_rd;
    logic [chnp_pkg::TAG_W-1:0] w_tag_rd;
    logic [BW-1:0] w_head_waddr;
    logic          w_head_we;
    logic [chnp_pkg::KEY_W-1:0] w_hash;
    logic [BW-1:0] w_bucket;
    logic [CW-1:0] w_lim_eff;
    logic [chnp_pkg::MAXM_W-1:0] w_cap;

    assign w_hash   = chnp_pkg::mix_key(i_key);
    assign w_bucket = w_hash[BW-1:0];
    assign w_cap    = (i_max_matches > chnp_pkg::MAXM_W'(CAPV)) ?
                      chnp_pkg::MAXM_W'(CAPV) : i_max_matches;
    assign w_lim_eff = (32'(r_limit) > 32'(POOL_DEPTH)) ?
                       NULL_LINK : CW'(r_limit);

    // Head RAM: written on alloc; the clear sweep drops valid bits instead.
    assign w_head_we    = i_ctl.alloc;
    assign w_head_waddr = r_bucket;
    assign w_head_wdata = r_count;

    chnp_ram #(.WIDTH(CW), .DEPTH(BUCKET_COUNT)) u_heads (
        .i_clk(i_clk), .i_we(w_head_we), .i_waddr(w_head_waddr),
        .i_wdata(w_head_wdata), .i_raddr(r_bucket), .o_rdata(w_head_rd));

    // The head read address stays on the bucket for the whole command, so the
    // old head is still on the read port when the new entry links to it.
    chnp_ram #(.WIDTH(CW), .DEPTH(POOL_DEPTH)) u_links (
        .i_clk(i_clk), .i_we(i_ctl.alloc), .i_waddr(PW'(r_count)),
        .i_wdata(w_head_eff),
        .i_raddr(PW'(r_ptr)), .o_rdata(w_link_rd));

    chnp_ram #(.WIDTH(chnp_pkg::KEY_W), .DEPTH(POOL_DEPTH)) u_keys (
        .i_clk(i_clk), .i_we(i_ctl.alloc), .i_waddr(PW'(r_count)),
        .i_wdata(r_key), .i_raddr(PW'(r_ptr)), .o_rdata(w_key_rd));

    chnp_ram #(.WIDTH(chnp_pkg::TAG_W), .DEPTH(POOL_DEPTH)) u_tags (
        .i_clk(i_clk), .i_we(i_ctl.alloc), .i_waddr(PW'(r_count)),
        .i_wdata(r_tag), .i_raddr(PW'(r_ptr)), .o_rdata(w_tag_rd));

    assign w_head_eff = r_head_vld_q ? w_head_rd : NULL_LINK;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_cmd    <= i_command;
            r_key    <= i_key;
            r_tag    <= i_tag;
            r_cap    <= w_cap;
            r_bucket <= w_bucket;
        end
        if (i_ctl.head_rd) begin
            r_head_vld_q <= r_head_vld[r_bucket];
        end
        if (i_ctl.head_load) begin
            r_ptr <= w_head_eff;
        end else if (i_ctl.node_adv) begin
            r_ptr <= w_link_rd;
        end
        if (i_ctl.pend_load) begin
            r_pend <= r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= chnp_pkg::LIMIT_W'(1024);
            r_hits      <= '0;
            r_clr_addr  <= '0;
            r_clr_done  <= 1'b0;
            r_head_vld  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_ctl.take) begin
                r_hits <= '0;
            end else if (i_ctl.hit_push) begin
                r_hits <= r_hits + HW'(1);
            end
            if (i_ctl.alloc) begin
                r_count <= r_count + CW'(1);
                r_head_vld[r_bucket] <= 1'b1;
            end
            // One head a cycle through the bucket table.
            if (i_ctl.clr_start) begin
                r_count    <= '0;
                r_clr_addr <= '0;
                r_clr_done <= 1'b0;
            end else if (i_ctl.clr_step) begin
                r_head_vld[r_clr_addr] <= 1'b0;
                r_clr_done <= (BCW'(r_clr_addr) == BCW'(BUCKET_COUNT - 1));
                r_clr_addr <= r_clr_addr + BW'(1);
            end
            if (i_ctl.res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_take) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_res_status <= i_ctl.res_status;
            r_res_last   <= i_ctl.res_last;
            if (i_ctl.res_use_ptr) begin
                r_res_index <= chnp_pkg::IDX_W'(r_ptr);
            end else if (i_ctl.res_use_cnt) begin
                r_res_index <= chnp_pkg::IDX_W'(r_count);
            end else if (i_ctl.res_use_pend) begin
                r_res_index <= chnp_pkg::IDX_W'(r_pend);
            end else begin
                r_res_index <= '0;
            end
        end
    end

    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.ptr_live    = (r_ptr < r_count);
        o_sts.key_eq      = (w_key_rd == r_key);
        o_sts.tag_eq      = (w_tag_rd == r_tag);
        o_sts.full        = (r_count >= w_lim_eff);
        o_sts.cap_zero    = (r_cap == '0);
        o_sts.cap_reached = (chnp_pkg::MAXM_W'(r_hits) + chnp_pkg::MAXM_W'(1) == r_cap);
        o_sts.hits_zero   = (r_hits == '0);
        o_sts.clr_done    = r_clr_done;
        o_sts.res_busy    = r_res_valid;
    end

    assign o_res_valid  = r_res_valid;
    assign o_res_index  = r_res_index;
    assign o_res_status = r_res_status;
    assign o_res_last   = r_res_last;

    `CHNP_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= NULL_LINK, "count overflow")
    `CHNP_ASSERT_NEXT(a_alloc_bump, i_clk, i_rst_n, i_ctl.alloc && !i_ctl.clr_start, r_count == $past(r_count) + CW'(1), "alloc did not bump count")
    `CHNP_ASSERT_IMPL(a_no_load_busy, i_clk, i_rst_n, i_ctl.res_load, !r_res_valid, "result overwritten")
endmodule

// ===== rtl/chnp_ctrl.sv =====
`include "chained_hash_node_pool_top_macros.svh"

module chnp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    output chnp_pkg::t_ctl o_ctl,
    input  chnp_pkg::t_sts i_sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HRD   = 4'd1;  // head read issued
    localparam logic [3:0] S_HLD   = 4'd2;  // load pointer
    localparam logic [3:0] S_NRD   = 4'd3;  // entry read issued
    localparam logic [3:0] S_CMP   = 4'd4;  // compare entry
    localparam logic [3:0] S_CLR   = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;  // send the held find-all match
    localparam logic [3:0] S_DONE  = 4'd7;  // walk over, decide
    localparam logic [3:0] S_PAD   = 4'd8;  // head RAM read latency

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctl       = '0;
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_ctl.take = 1'b1;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                if (i_sts.cmd == chnp_pkg::CMD_CLEAR) begin
                    o_ctl.clr_start = 1'b1;
                    n_state = S_CLR;
                end else begin
                    o_ctl.head_rd = 1'b1;
                    n_state = S_PAD;
                end
            end
            S_PAD: n_state = S_HLD;
            S_HLD: begin
                o_ctl.head_load = 1'b1;
                n_state = S_NRD;
            end
            S_NRD: begin
                if (!i_sts.ptr_live || (i_sts.cmd == chnp_pkg::CMD_ALL && i_sts.cap_zero)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.cmd == chnp_pkg::CMD_ALL) begin
                    if (i_sts.key_eq) begin
                        // Hold this match back; release the one held before.
                        if (i_sts.hits_zero || !i_sts.res_busy) begin
                            if (!i_sts.hits_zero) begin
                                o_ctl.res_load     = 1'b1;
                                o_ctl.res_use_pend = 1'b1;
                                o_ctl.res_status   = chnp_pkg::ST_FOUND;
                            end
                            o_ctl.pend_load = 1'b1;
                            o_ctl.hit_push  = 1'b1;
                            if (i_sts.cap_reached) begin
                                n_state = S_OUT;
                            end else begin
                                o_ctl.node_adv = 1'b1;
                                n_state = S_NRD;
                            end
                        end
                    end else begin
                        o_ctl.node_adv = 1'b1;
                        n_state = S_NRD;
                    end
                end else if (i_sts.key_eq && i_sts.tag_eq) begin
                    if (!i_sts.res_busy) begin
                        o_ctl.res_load    = 1'b1;
                        o_ctl.res_use_ptr = 1'b1;
                        o_ctl.res_status  = chnp_pkg::ST_FOUND;
                        o_ctl.res_last    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_ctl.node_adv = 1'b1;
                    n_state = S_NRD;
                end
            end
            S_DONE: begin
                if (i_sts.cmd == chnp_pkg::CMD_ALL && !i_sts.hits_zero) begin
                    n_state = S_OUT;
                end else if (!i_sts.res_busy) begin
                    o_ctl.res_load = 1'b1;
                    o_ctl.res_last = 1'b1;
                    n_state = S_IDLE;
                    if (i_sts.cmd == chnp_pkg::CMD_GET && !i_sts.full) begin
                        o_ctl.alloc       = 1'b1;
                        o_ctl.res_use_cnt = 1'b1;
                        o_ctl.res_status  = chnp_pkg::ST_CREATED;
                    end else if (i_sts.cmd == chnp_pkg::CMD_GET) begin
                        o_ctl.res_status = chnp_pkg::ST_FULL;
                    end else begin
                        o_ctl.res_status = chnp_pkg::ST_MISS;
                    end
                end
            end
            S_OUT: begin
                // Final find-all beat carries last.
                if (!i_sts.res_busy) begin
                    o_ctl.res_load     = 1'b1;
                    o_ctl.res_use_pend = 1'b1;
                    o_ctl.res_status   = chnp_pkg::ST_FOUND;
                    o_ctl.res_last     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                if (i_sts.clr_done) begin
                    if (!i_sts.res_busy) begin
                        o_ctl.res_load   = 1'b1;
                        o_ctl.res_status = chnp_pkg::ST_CLEARED;
                        o_ctl.res_last   = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_ctl.clr_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `CHNP_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_cmd_ready, r_state == S_IDLE, "ready outside idle")
    `CHNP_ASSERT_IMPL(a_alloc_done, i_clk, i_rst_n, o_ctl.alloc, r_state == S_DONE && o_ctl.res_load, "alloc without result")
    `CHNP_ASSERT_NEXT(a_take_moves, i_clk, i_rst_n, o_ctl.take, r_state == S_HRD, "command not started")
endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE  = 1024;
    localparam int NO_LINK    = POOL_SIZE;
    localparam int SETTLE     = 300;   // covers a clear sweep of every bucket with margin
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [chnp_pkg::IDX_W-1:0]  entry_index;
        logic [chnp_pkg::STAT_W-1:0] status;
        logic                        last;
    } t_beat;

    logic clk;
    logic rst_n;

    chnp_cmd_if cmd_ch ();
    chnp_res_if res_ch ();
    chnp_cfg_if cfg_ch ();

    chained_hash_node_pool_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .cfg     (cfg_ch)
    );

    // Mirror of the pool: bucket heads, chain links, keys, tags, count and limit.
    int                          pool_heads [256];
    int                          pool_links [POOL_SIZE];
    logic [chnp_pkg::KEY_W-1:0]  pool_keys  [POOL_SIZE];
    logic [chnp_pkg::TAG_W-1:0]  pool_tags  [POOL_SIZE];
    int                          pool_count;
    int                          pool_limit;

    t_beat       pending_beats [$];
    int          mismatches;
    bit          hold_req;
    bit          no_gaps;
    int          idle_cycles = 0;
    logic [chnp_pkg::KEY_W-1:0] key_set [12];

    // Clock: 20 ns period.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [7:0] bucket_for(logic [chnp_pkg::KEY_W-1:0] k);
        logic [31:0] v;
        v = k;
        v = v + ~(v << 15);
        v = v ^ (v >> 10);
        v = v + (v << 3);
        v = v ^ (v >> 6);
        v = v + ~(v << 11);
        v = v ^ (v >> 16);
        return v[7:0];
    endfunction

    function automatic int lookup_entry(logic [chnp_pkg::KEY_W-1:0] k,
                                        logic [chnp_pkg::TAG_W-1:0] t);
        int i;
        i = pool_heads[bucket_for(k)];
        while (i < pool_count) begin
            if (pool_keys[i] == k && pool_tags[i] == t) return i;
            i = pool_links[i];
        end
        return NO_LINK;
    endfunction

    function automatic void push_beat(int idx, logic [chnp_pkg::STAT_W-1:0] st, logic lst);
        t_beat b;
        b.entry_index = idx[chnp_pkg::IDX_W-1:0];
        b.status      = st;
        b.last        = lst;
        pending_beats.push_back(b);
    endfunction

    // Work out the beats one accepted command causes and update the mirror.
    function automatic void predict_beats(logic [chnp_pkg::CMD_W-1:0] c,
                                          logic [chnp_pkg::KEY_W-1:0] k,
                                          logic [chnp_pkg::TAG_W-1:0] t,
                                          logic [chnp_pkg::MAXM_W-1:0] m);
        int hit, lim, cap, i, n;
        int found [$];
        case (c)
            chnp_pkg::CMD_GET: begin
                hit = lookup_entry(k, t);
                lim = (pool_limit > POOL_SIZE) ? POOL_SIZE : pool_limit;
                if (hit != NO_LINK) begin
                    push_beat(hit, chnp_pkg::ST_FOUND, 1'b1);
                end else if (pool_count >= lim) begin
                    push_beat(0, chnp_pkg::ST_FULL, 1'b1);
                end else begin
                    n = pool_count;
                    pool_keys[n]  = k;
                    pool_tags[n]  = t;
                    pool_links[n] = pool_heads[bucket_for(k)];
                    pool_heads[bucket_for(k)] = n;
                    pool_count++;
                    push_beat(n, chnp_pkg::ST_CREATED, 1'b1);
                end
            end
            chnp_pkg::CMD_FIND: begin
                hit = lookup_entry(k, t);
                if (hit != NO_LINK) push_beat(hit, chnp_pkg::ST_FOUND, 1'b1);
                else push_beat(0, chnp_pkg::ST_MISS, 1'b1);
            end
            chnp_pkg::CMD_ALL: begin
                cap = (m > chnp_pkg::RES_CAP) ? chnp_pkg::RES_CAP : m;
                i = pool_heads[bucket_for(k)];
                while (i < pool_count && found.size() < cap) begin
                    if (pool_keys[i] == k) found.push_back(i);
                    i = pool_links[i];
                end
                if (found.size() == 0) begin
                    push_beat(0, chnp_pkg::ST_MISS, 1'b1);
                end else begin
                    foreach (found[j])
                        push_beat(found[j], chnp_pkg::ST_FOUND, j == found.size() - 1);
                end
            end
            default: begin
                foreach (pool_heads[b]) pool_heads[b] = NO_LINK;
                pool_count = 0;
                push_beat(0, chnp_pkg::ST_CLEARED, 1'b1);
            end
        endcase
    endfunction

    // Offer one command beat after a random gap; valid stays high on exit.
    task automatic send_command(logic [chnp_pkg::CMD_W-1:0] c,
                                logic [chnp_pkg::KEY_W-1:0] k,
                                logic [chnp_pkg::TAG_W-1:0] t,
                                logic [chnp_pkg::MAXM_W-1:0] m);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= c;
        cmd_ch.key         <= k;
        cmd_ch.tag         <= t;
        cmd_ch.max_matches <= m;
        do @(posedge clk); while (!cmd_ch.ready);
        predict_beats(c, k, t, m);
    endtask

    // Drop valid and let the block drain completely.
    task automatic drain_block();
        cmd_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        drain_block();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value[chnp_pkg::LIMIT_W-1:0];
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        pool_limit = value;
    endtask

    // Result side: random stalls, optional long hold-off, compare each beat.
    initial begin : result_sink
        int    n;
        t_beat want;
        res_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 14);
            if (n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: index %0d status %0d last %0b",
                             res_ch.entry_index, res_ch.status, res_ch.last);
            end else begin
                want = pending_beats.pop_front();
                if (res_ch.entry_index !== want.entry_index || res_ch.status !== want.status ||
                        res_ch.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected index %0d status %0d last %0b, got %0d %0d %0b",
                                 want.entry_index, want.status, want.last,
                                 res_ch.entry_index, res_ch.status, res_ch.last);
                end
            end
        end
    end

    task automatic random_command();
        logic [chnp_pkg::CMD_W-1:0] c;
        logic [chnp_pkg::KEY_W-1:0] k;
        logic [chnp_pkg::TAG_W-1:0] t;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 42) c = chnp_pkg::CMD_GET;
        else if (pick < 66) c = chnp_pkg::CMD_FIND;
        else if (pick < 97) c = chnp_pkg::CMD_ALL;
        else c = chnp_pkg::CMD_CLEAR;
        // Mostly reuse a small key set so lookups hit and chains grow.
        k = ($urandom_range(0, 9) < 8) ? key_set[$urandom_range(0, 11)] : $urandom;
        t = ($urandom_range(0, 3) != 0) ? chnp_pkg::TAG_W'($urandom_range(0, 3)) :
                                          chnp_pkg::TAG_W'($urandom_range(0, 255));
        send_command(c, k, t, chnp_pkg::MAXM_W'($urandom_range(0, 15)));
    endtask

    // Field extremes, every command, hits, misses and find-all caps.
    task automatic test_directed();
        send_command(chnp_pkg::CMD_GET, 32'h0, 8'h00, 4'd0);
        send_command(chnp_pkg::CMD_GET, 32'hFFFF_FFFF, 8'hFF, 4'd15);
        send_command(chnp_pkg::CMD_GET, 32'h0, 8'h00, 4'd0);
        send_command(chnp_pkg::CMD_FIND, 32'hFFFF_FFFF, 8'hFF, 4'd0);
        send_command(chnp_pkg::CMD_FIND, 32'hFFFF_FFFF, 8'h00, 4'd0);
        send_command(chnp_pkg::CMD_FIND, 32'h1234_5678, 8'h5A, 4'd0);
        send_command(chnp_pkg::CMD_GET, 32'h0, 8'h01, 4'd0);
        send_command(chnp_pkg::CMD_GET, 32'h0, 8'hFF, 4'd0);
        send_command(chnp_pkg::CMD_ALL, 32'h0, 8'h00, 4'd15);
        send_command(chnp_pkg::CMD_ALL, 32'h0, 8'h00, 4'd8);
        send_command(chnp_pkg::CMD_ALL, 32'h0, 8'h00, 4'd1);
        send_command(chnp_pkg::CMD_ALL, 32'h0, 8'h00, 4'd0);
        send_command(chnp_pkg::CMD_ALL, 32'hDEAD_BEEF, 8'h00, 4'd8);
        send_command(chnp_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF, 4'd15);
        send_command(chnp_pkg::CMD_FIND, 32'h0, 8'h00, 4'd0);
        send_command(chnp_pkg::CMD_ALL, 32'h0, 8'h00, 4'd8);
        send_command(chnp_pkg::CMD_GET, 32'hA5A5_5A5A, 8'h3C, 4'd0);
    endtask

    // Tiny limits: full pool, limit lowered under the count, saturated limit.
    task automatic test_pool_full();
        write_limit(1);
        send_command(chnp_pkg::CMD_CLEAR, 32'h0, 8'h0, 4'd0);
        send_command(chnp_pkg::CMD_GET, 32'h11, 8'h1, 4'd0);
        send_command(chnp_pkg::CMD_GET, 32'h22, 8'h2, 4'd0);
        send_command(chnp_pkg::CMD_GET, 32'h11, 8'h1, 4'd0);
        write_limit(4);
        send_command(chnp_pkg::CMD_GET, 32'h22, 8'h2, 4'd0);
        send_command(chnp_pkg::CMD_GET, 32'h33, 8'h3, 4'd0);
        write_limit(2);
        send_command(chnp_pkg::CMD_GET, 32'h44, 8'h4, 4'd0);
        send_command(chnp_pkg::CMD_FIND, 32'h33, 8'h3, 4'd0);
        write_limit(2047);
        send_command(chnp_pkg::CMD_GET, 32'h44, 8'h4, 4'd0);
    endtask

    // Random phases under several limits.
    task automatic test_random();
        int limits [4] = '{1024, 9, 2047, 30};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            for (int i = 0; i < 60; i++) begin
                if (i % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
                random_command();
            end
            no_gaps = 1'b0;
        end
    endtask

    // Hold the result side off while commands keep coming, so the block backs up.
    task automatic test_backpressure();
        drain_block();
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (int i = 0; i < 30; i++) random_command();
        no_gaps = 1'b0;
    endtask

    initial begin
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= chnp_pkg::CMD_GET;
        cmd_ch.key     <= '0;
        cmd_ch.tag     <= '0;
        cmd_ch.max_matches <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        mismatches  = 0;
        hold_req    = 1'b0;
        no_gaps     = 1'b0;
        pool_count  = 0;
        pool_limit  = 1024;
        foreach (pool_heads[b]) pool_heads[b] = NO_LINK;
        foreach (key_set[i]) key_set[i] = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pool_full();
        test_random();
        test_backpressure();

        drain_block();
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/chnp_pkg.sv
rtl/chnp_if.sv
rtl/chnp_res_if.sv
rtl/chnp_cfg_if.sv
rtl/chnp_ram.sv
rtl/chnp_datapath.sv
rtl/chnp_ctrl.sv
rtl/chained_hash_node_pool_top.sv
tb/testbench.sv
